[hw/rtl/rope_pkg.sv]
// Shared constants, types and codes for the rotary position embedding block.
// No dependencies.
package rope_pkg;

  localparam int unsigned MAX_ROT_DIM   = 128;
  localparam int unsigned MAX_POSITIONS = 2048;
  localparam int unsigned DATA_BITS     = 16;
  localparam int unsigned FRAC_BITS     = 14;

  localparam int unsigned POS_W      = 11;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned ROT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned COL_W      = $clog2(MAX_ROT_DIM);
  localparam int unsigned ROW_W      = $clog2(MAX_POSITIONS);
  localparam int unsigned TBL_DEPTH  = MAX_POSITIONS * MAX_ROT_DIM;
  localparam int unsigned PEND_DEPTH = MAX_ROT_DIM / 2;
  localparam int unsigned PEND_W     = $clog2(PEND_DEPTH);
  localparam int unsigned PROD_W     = 2 * DATA_BITS;
  localparam int unsigned SUM_W      = PROD_W + 2;

  localparam int unsigned JOBQ_DEPTH_DFLT = 4;
  localparam int unsigned OUTQ_DEPTH_DFLT = 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DATA = 1'b1
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_DIM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NEOX    = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [DATA_BITS-1:0] x1;
    logic signed [DATA_BITS-1:0] x2;
    logic signed [DATA_BITS-1:0] c;
    logic signed [DATA_BITS-1:0] s;
    logic [IDX_W-1:0]            first_idx;
    logic [IDX_W-1:0]            idx;
    logic                        done;
  } job_t;

endpackage

[hw/rtl/rope_ram.sv]
// Generic RAM: one write port, NUM_RD registered read ports.
// No dependencies.
module rope_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned NUM_RD = 1,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [NUM_RD-1:0] re_i,
  input  logic [ADDR_W-1:0] raddr_i [NUM_RD],
  output logic [WIDTH-1:0]  rdata_o [NUM_RD]
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    for (int r = 0; r < NUM_RD; r++) begin
      if (re_i[r]) begin
        rdata_o[r] <= mem_q[raddr_i[r]];
      end
    end
  end

endmodule

[hw/rtl/rope_front.sv]
// Front end: config registers, input classification, cos/sin table and pair buffer.
// Depends on rope_pkg and rope_ram.
module rope_front import rope_pkg::*; #(
  parameter int unsigned JOBQ_DEPTH = JOBQ_DEPTH_DFLT,
  localparam int unsigned JQ_CNT_W = $clog2(JOBQ_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        command_i,
  input  logic [POS_W-1:0]            position_i,
  input  logic [IDX_W-1:0]            element_index_i,
  input  logic signed [DATA_BITS-1:0] value_i,
  input  logic [JQ_CNT_W-1:0]         jobq_count_i,
  output logic                        job_valid_o,
  output job_t                        job_o
);

  localparam logic [ROT_W-1:0] ROT_MAX = ROT_W'(MAX_ROT_DIM & ~32'd1);
  localparam logic [ROT_W-1:0] ROT_MIN = ROT_W'(2);
  localparam int unsigned TBL_AW = $clog2(TBL_DEPTH);

  logic [ROT_W-1:0] rot_dim_q;
  logic             neox_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_dim_q <= ROT_W'(128);
      neox_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROT_DIM: rot_dim_q <= cfg_data_i[ROT_W-1:0];
        CFG_NEOX:    neox_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic             accept, is_data, pos_ok;
  logic [ROT_W-1:0] rd_even, rd, idx_ext;
  logic [IDX_W-1:0] half, pair, first_idx, s_col;
  logic             second, in_rot, pair_ok, done;
  logic             use_item, pend_we, job_go, tbl_we;

  always_comb begin
    accept  = push_i & ~full_o;
    is_data = (cmd_e'(command_i) == CMD_DATA);
    pos_ok  = (32'(position_i) < MAX_POSITIONS);

    rd_even = {rot_dim_q[ROT_W-1:1], 1'b0};
    priority if (rd_even > ROT_MAX) begin
      rd = ROT_MAX;
    end else if (rd_even < ROT_MIN) begin
      rd = ROT_MIN;
    end else begin
      rd = rd_even;
    end
    half    = rd[ROT_W-1:1];
    idx_ext = {1'b0, element_index_i};
    in_rot  = (idx_ext < rd);

    if (neox_q) begin
      second    = (idx_ext >= {1'b0, half});
      pair      = second ? (element_index_i - half) : element_index_i;
      first_idx = pair;
    end else begin
      second    = element_index_i[0];
      pair      = {1'b0, element_index_i[IDX_W-1:1]};
      first_idx = {element_index_i[IDX_W-1:1], 1'b0};
    end
    pair_ok = (32'(pair) < PEND_DEPTH);
    s_col   = half + pair;
    done    = (idx_ext == (rd - ROT_W'(1)));

    use_item = accept & is_data & in_rot & pair_ok;
    pend_we  = use_item & ~second;
    job_go   = use_item & second;
    tbl_we   = accept & ~is_data & pos_ok & (32'(element_index_i) < MAX_ROT_DIM);
  end

  logic [TBL_AW-1:0]    tbl_raddr [2];
  logic [DATA_BITS-1:0] tbl_rdata [2];
  logic [PEND_W-1:0]    pend_raddr [1];
  logic [DATA_BITS-1:0] pend_rdata [1];

  always_comb begin
    tbl_raddr[0]  = {position_i[ROW_W-1:0], pair[COL_W-1:0]};
    tbl_raddr[1]  = {position_i[ROW_W-1:0], s_col[COL_W-1:0]};
    pend_raddr[0] = pair[PEND_W-1:0];
  end

  rope_ram #(
    .WIDTH  (DATA_BITS),
    .DEPTH  (TBL_DEPTH),
    .NUM_RD (2)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i ({position_i[ROW_W-1:0], element_index_i[COL_W-1:0]}),
    .wdata_i (value_i),
    .re_i    ({job_go, job_go}),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  rope_ram #(
    .WIDTH  (DATA_BITS),
    .DEPTH  (PEND_DEPTH),
    .NUM_RD (1)
  ) u_pending (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pair[PEND_W-1:0]),
    .wdata_i (value_i),
    .re_i    (job_go),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  logic                        s1_valid_q;
  logic signed [DATA_BITS-1:0] s1_x2_q;
  logic [IDX_W-1:0]            s1_first_q, s1_idx_q;
  logic                        s1_done_q, s1_pos_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= job_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_go) begin
      s1_x2_q     <= value_i;
      s1_first_q  <= first_idx;
      s1_idx_q    <= element_index_i;
      s1_done_q   <= done;
      s1_pos_ok_q <= pos_ok;
    end
  end

  always_comb begin
    job_valid_o     = s1_valid_q;
    job_o.x1        = pend_rdata[0];
    job_o.x2        = s1_x2_q;
    job_o.c         = s1_pos_ok_q ? tbl_rdata[0] : '0;
    job_o.s         = s1_pos_ok_q ? tbl_rdata[1] : '0;
    job_o.first_idx = s1_first_q;
    job_o.idx       = s1_idx_q;
    job_o.done      = s1_done_q;
    // reserve a slot for the beat still in the read stage
    full_o = ((32'(jobq_count_i) + 32'(s1_valid_q)) >= JOBQ_DEPTH);
  end

endmodule

[hw/rtl/rope_jobq.sv]
// Short queue of rotation jobs between front and back end.
// Depends on rope_pkg.
module rope_jobq import rope_pkg::*; #(
  parameter int unsigned DEPTH = JOBQ_DEPTH_DFLT,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  job_t             push_data_i,
  input  logic             pop_i,
  output job_t             data_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  job_t             entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_pop;

  assign do_pop  = pop_i & ~empty_o;
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/rope_back.sv]
// Back end: multiply stage, round/saturate stage and result queue.
// Depends on rope_pkg.
module rope_back import rope_pkg::*; #(
  parameter int unsigned OUTQ_DEPTH = OUTQ_DEPTH_DFLT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  job_t                        job_i,
  input  logic                        job_valid_i,
  output logic                        job_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [IDX_W-1:0]            out_index_o,
  output logic signed [DATA_BITS-1:0] out_value_o,
  output logic                        last_of_item_o,
  output logic                        row_done_o
);

  localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned RW    = SUM_W - FRAC_BITS;
  localparam logic signed [SUM_W-1:0] RND    = SUM_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [RW-1:0]    SAT_HI = RW'((64'd1 << (DATA_BITS - 1)) - 64'd1);
  localparam logic signed [RW-1:0]    SAT_LO = -SAT_HI - RW'(1);

  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic signed [DATA_BITS-1:0] val;
    logic                        last;
    logic                        done;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (32'(p) == OUTQ_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic signed [DATA_BITS-1:0] round_sat(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b,
    input logic                     sub
  );
    logic signed [SUM_W-1:0] ea, eb, t;
    logic signed [RW-1:0]    r;
    ea = a;
    eb = b;
    t  = (sub ? (ea - eb) : (ea + eb)) + RND;
    r  = t[SUM_W-1:FRAC_BITS];
    priority if (r > SAT_HI) begin
      return SAT_HI[DATA_BITS-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[DATA_BITS-1:0];
    end else begin
      return r[DATA_BITS-1:0];
    end
  endfunction

  logic [CNT_W-1:0] ocount_q;
  logic             mv_q, rv_q;

  // take a job only if both of its results are sure to find room
  assign job_pop_o = job_valid_i &
      ((32'(ocount_q) + 2 * (32'(mv_q) + 32'(rv_q)) + 2) <= OUTQ_DEPTH);

  logic signed [PROD_W-1:0] p_x1c_q, p_x2s_q, p_x2c_q, p_x1s_q;
  logic [IDX_W-1:0]         m_first_q, m_idx_q;
  logic                     m_done_q;

  logic signed [DATA_BITS-1:0] r_o1_q, r_o2_q;
  logic [IDX_W-1:0]            r_first_q, r_idx_q;
  logic                        r_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      mv_q <= job_pop_o;
      rv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      p_x1c_q   <= job_i.x1 * job_i.c;
      p_x2s_q   <= job_i.x2 * job_i.s;
      p_x2c_q   <= job_i.x2 * job_i.c;
      p_x1s_q   <= job_i.x1 * job_i.s;
      m_first_q <= job_i.first_idx;
      m_idx_q   <= job_i.idx;
      m_done_q  <= job_i.done;
    end
    if (mv_q) begin
      r_o1_q    <= round_sat(p_x1c_q, p_x2s_q, 1'b1);
      r_o2_q    <= round_sat(p_x2c_q, p_x1s_q, 1'b0);
      r_first_q <= m_first_q;
      r_idx_q   <= m_idx_q;
      r_done_q  <= m_done_q;
    end
  end

  result_t          oq_q [OUTQ_DEPTH];
  logic [PTR_W-1:0] owr_ptr_q, ord_ptr_q, owr_next;
  logic             do_pop;
  result_t          head;

  assign owr_next = ptr_inc(owr_ptr_q);
  assign do_pop   = pop_i & ~empty_o;
  assign empty_o  = (ocount_q == '0);
  assign head     = oq_q[ord_ptr_q];

  assign out_index_o    = head.idx;
  assign out_value_o    = head.val;
  assign last_of_item_o = head.last;
  assign row_done_o     = head.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_ptr_q <= '0;
      ord_ptr_q <= '0;
      ocount_q  <= '0;
    end else begin
      if (rv_q) begin
        owr_ptr_q <= ptr_inc(owr_next);
      end
      if (do_pop) begin
        ord_ptr_q <= ptr_inc(ord_ptr_q);
      end
      ocount_q <= ocount_q + (rv_q ? CNT_W'(2) : CNT_W'(0)) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      oq_q[owr_ptr_q] <= '{idx: r_first_q, val: r_o1_q, last: 1'b0, done: r_done_q};
      oq_q[owr_next]  <= '{idx: r_idx_q, val: r_o2_q, last: 1'b1, done: r_done_q};
    end
  end

endmodule

[hw/rtl/rotary_position_embedding_top.sv]
// Top level of the rotary position embedding block.
// Depends on rope_pkg, rope_front, rope_jobq and rope_back.
//
//   channel  dir  handshake        beat fields
//   input    in   push_i / full_o  command_i position_i element_index_i value_i
//   result   out  empty_o / pop_i  out_index_o out_value_o last_of_item_o row_done_o
//   config   in   cfg_we_i         cfg_idx_i cfg_data_i
//
// One input beat per cycle while results drain as fast as they are made; the table
// RAM takes both coefficient reads of a pair in the cycle the second element is
// accepted.
// Results reach the result queue via the read, job queue, multiply and round stages.
// Reset clears config to 128 / neox and empties both queues; the table and the
// pair buffer are not cleared. full_o rises when the job queue backs up behind a
// result queue with no room: when pop_i holds off, or when second elements come
// faster than pop_i drains the two result beats that each makes.
module rotary_position_embedding_top import rope_pkg::*; #(
  parameter int unsigned JOBQ_DEPTH = JOBQ_DEPTH_DFLT,
  parameter int unsigned OUTQ_DEPTH = OUTQ_DEPTH_DFLT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        command_i,
  input  logic [POS_W-1:0]            position_i,
  input  logic [IDX_W-1:0]            element_index_i,
  input  logic signed [DATA_BITS-1:0] value_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [IDX_W-1:0]            out_index_o,
  output logic signed [DATA_BITS-1:0] out_value_o,
  output logic                        last_of_item_o,
  output logic                        row_done_o
);

  localparam int unsigned JQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  logic                job_push, jobq_empty, job_pop;
  job_t                job_in, job_head;
  logic [JQ_CNT_W-1:0] jobq_count;

  rope_front #(
    .JOBQ_DEPTH (JOBQ_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push_i),
    .full_o          (full_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .element_index_i (element_index_i),
    .value_i         (value_i),
    .jobq_count_i    (jobq_count),
    .job_valid_o     (job_push),
    .job_o           (job_in)
  );

  rope_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .pop_i       (job_pop),
    .data_o      (job_head),
    .empty_o     (jobq_empty),
    .count_o     (jobq_count)
  );

  rope_back #(
    .OUTQ_DEPTH (OUTQ_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_head),
    .job_valid_i    (~jobq_empty),
    .job_pop_o      (job_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .out_index_o    (out_index_o),
    .out_value_o    (out_value_o),
    .last_of_item_o (last_of_item_o),
    .row_done_o     (row_done_o)
  );

endmodule
